/* design/fcp_pkg.sv */
// Shared types and constants for the framed command parser.
`timescale 1ns / 1ps

package fcp_pkg;

    // Frame and type characters
    localparam logic [7:0] CH_OPEN  = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE = 8'h29; // ')'
    localparam logic [7:0] CH_ID    = 8'h49; // 'I'
    localparam logic [7:0] CH_ACK   = 8'h41; // 'A'
    localparam logic [7:0] CH_END   = 8'h45; // 'E'
    localparam logic [7:0] CH_HASH  = 8'h23; // '#'
    localparam logic [7:0] CH_ONE   = 8'h31; // '1'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'
    localparam logic [7:0] CH_PLUS  = 8'h2b; // '+'
    localparam logic [7:0] CH_MINUS = 8'h2d; // '-'

    // Result kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ID   = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fcp_req_t;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         kind;
        logic signed [31:0] id_value;
        logic [63:0]        key_bytes;
        logic               id_valid;
        logic               id_received;
        logic               ack_received;
        logic               ack_good;
        logic               end_received;
    } fcp_rsp_t;

    // Package fields as seen on the closing byte
    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  pkg_type;
        logic [7:0]  ack_marker;
        logic [7:0]  ack_digit;
        logic        hash_seen;
        logic        sign_negative;
        logic [31:0] id_acc;
        logic [63:0] key_shift;
        logic        key_ok;
    } frame_info_t;

endpackage

/* design/fcp_parse.sv */
// Per-package byte parser: framing, type, id digits and key capture.
`timescale 1ns / 1ps

module fcp_parse #(
    parameter int KEY_LEN = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  fcp_pkg::fcp_req_t    req,
    output fcp_pkg::frame_info_t info
);

    localparam int CNT_W = $clog2(KEY_LEN + 2);

    logic [2:0]       byte_position_reg, byte_position_next;
    logic             first_was_open_reg, first_was_open_next;
    logic [7:0]       package_type_reg, package_type_next;
    logic [7:0]       ack_marker_reg, ack_marker_next;
    logic [7:0]       ack_digit_reg, ack_digit_next;
    logic             hash_seen_reg, hash_seen_next;
    logic             digits_stopped_reg, digits_stopped_next;
    logic             sign_negative_reg, sign_negative_next;
    logic [31:0]      id_acc_reg, id_acc_next;
    logic [63:0]      key_shift_reg, key_shift_next;
    logic [CNT_W-1:0] key_count_reg, key_count_next;

    logic [7:0] b;
    assign b = req.data_byte;

    always_comb begin
        byte_position_next  = byte_position_reg;
        first_was_open_next = first_was_open_reg;
        package_type_next   = package_type_reg;
        ack_marker_next     = ack_marker_reg;
        ack_digit_next      = ack_digit_reg;
        hash_seen_next      = hash_seen_reg;
        digits_stopped_next = digits_stopped_reg;
        sign_negative_next  = sign_negative_reg;
        id_acc_next         = id_acc_reg;
        key_shift_next      = key_shift_reg;
        key_count_next      = key_count_reg;

        if (take) begin
            if (req.last_byte) begin
                byte_position_next  = 3'd0;
                first_was_open_next = 1'b0;
                package_type_next   = 8'd0;
                ack_marker_next     = 8'd0;
                ack_digit_next      = 8'd0;
                hash_seen_next      = 1'b0;
                digits_stopped_next = 1'b0;
                sign_negative_next  = 1'b0;
                id_acc_next         = 32'd0;
                key_shift_next      = 64'd0;
                key_count_next      = '0;
            end else begin
                case (byte_position_reg)
                    3'd0: first_was_open_next = (b == fcp_pkg::CH_OPEN);
                    3'd1: package_type_next = b;
                    3'd2: ack_marker_next = b;
                    3'd3: ack_digit_next = b;
                    default: ;
                endcase

                if (byte_position_reg >= 3'd3) begin
                    if (!hash_seen_reg) begin
                        if (b == fcp_pkg::CH_HASH) begin
                            hash_seen_next = 1'b1;
                        end else if (!digits_stopped_reg) begin
                            if (byte_position_reg == 3'd3 &&
                                (b == fcp_pkg::CH_MINUS || b == fcp_pkg::CH_PLUS)) begin
                                sign_negative_next = (b == fcp_pkg::CH_MINUS);
                            end else if (b >= fcp_pkg::CH_ZERO && b <= fcp_pkg::CH_NINE) begin
                                // acc * 10 + digit, wraps at 32 bits
                                id_acc_next = (id_acc_reg << 3) + (id_acc_reg << 1)
                                            + {28'd0, b[3:0]};
                            end else begin
                                digits_stopped_next = 1'b1;
                            end
                        end
                    end else begin
                        for (int i = 0; i < 8; i++) begin
                            if (i < KEY_LEN && key_count_reg == CNT_W'(i)) begin
                                key_shift_next[8*i +: 8] = key_shift_reg[8*i +: 8] | b;
                            end
                        end
                        if (key_count_reg <= CNT_W'(KEY_LEN)) begin
                            key_count_next = key_count_reg + CNT_W'(1);
                        end
                    end
                end

                if (byte_position_reg < 3'd4) begin
                    byte_position_next = byte_position_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= 3'd0;
            first_was_open_reg <= 1'b0;
            package_type_reg   <= 8'd0;
            ack_marker_reg     <= 8'd0;
            ack_digit_reg      <= 8'd0;
            hash_seen_reg      <= 1'b0;
            digits_stopped_reg <= 1'b0;
            sign_negative_reg  <= 1'b0;
            id_acc_reg         <= 32'd0;
            key_shift_reg      <= 64'd0;
            key_count_reg      <= '0;
        end else begin
            byte_position_reg  <= byte_position_next;
            first_was_open_reg <= first_was_open_next;
            package_type_reg   <= package_type_next;
            ack_marker_reg     <= ack_marker_next;
            ack_digit_reg      <= ack_digit_next;
            hash_seen_reg      <= hash_seen_next;
            digits_stopped_reg <= digits_stopped_next;
            sign_negative_reg  <= sign_negative_next;
            id_acc_reg         <= id_acc_next;
            key_shift_reg      <= key_shift_next;
            key_count_reg      <= key_count_next;
        end
    end

    // Closing byte lands on the slot it would fill, so use it there.
    always_comb begin
        info.frame_ok      = (b == fcp_pkg::CH_CLOSE) && (byte_position_reg != 3'd0)
                           && first_was_open_reg;
        info.pkg_type      = (byte_position_reg == 3'd1) ? b : package_type_reg;
        info.ack_marker    = (byte_position_reg == 3'd2) ? b : ack_marker_reg;
        info.ack_digit     = (byte_position_reg == 3'd3) ? b : ack_digit_reg;
        info.hash_seen     = hash_seen_reg;
        info.sign_negative = sign_negative_reg;
        info.id_acc        = id_acc_reg;
        info.key_shift     = key_shift_reg;
        info.key_ok        = (key_count_reg == CNT_W'(KEY_LEN));
    end

endmodule

/* design/framed_command_parser.sv */
// Top level of the framed command parser: stored id, key, flags and result register.
`timescale 1ns / 1ps

// Framed command parser.
// Input channel (s_valid/s_ready/s_data): one package byte per request, with
// last_byte set on the final byte. A package is "(", type, body, ")".
// Output channel (m_valid/m_ready/m_data): one result per package, produced
// from its final byte; other bytes produce nothing.
// Latency: the result is valid the cycle after the final byte is accepted.
// Throughput: one byte per cycle while s_ready is high. All per-byte work
// (framing checks, the decimal id step acc*10+digit, key byte insert) sits
// between the parser state registers and the result register.
// Stall: a pending result is held in the output register; s_ready drops only
// while that register is full and m_ready is low, so bytes keep flowing as
// soon as the result is taken.
// Reset (aresetn low, synchronous): parser state, stored id/key and all
// flags clear to zero, and no result is pending.
// KEY_LEN sets how many key bytes an id package must carry (1 to 8).
module framed_command_parser #(
    parameter int KEY_LEN = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcp_pkg::fcp_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fcp_pkg::fcp_rsp_t m_data
);

    logic                 take;
    logic                 close_pkg;
    fcp_pkg::frame_info_t info;

    logic [31:0] stored_id_reg, stored_id_next;
    logic [63:0] stored_key_reg, stored_key_next;
    logic        id_valid_reg, id_valid_next;
    logic        id_received_reg, id_received_next;
    logic        ack_received_reg, ack_received_next;
    logic        ack_good_reg, ack_good_next;
    logic        end_received_reg, end_received_next;
    logic        accepted;
    logic [1:0]  kind;

    logic              m_valid_reg;
    fcp_pkg::fcp_rsp_t m_data_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign take      = s_valid && s_ready;
    assign close_pkg = take && s_data.last_byte;

    fcp_parse #(
        .KEY_LEN(KEY_LEN)
    ) u_parse (
        .aclk   (aclk),
        .aresetn(aresetn),
        .take   (take),
        .req    (s_data),
        .info   (info)
    );

    // Package decode on the closing byte
    always_comb begin
        stored_id_next    = stored_id_reg;
        stored_key_next   = stored_key_reg;
        id_valid_next     = id_valid_reg;
        id_received_next  = id_received_reg;
        ack_received_next = ack_received_reg;
        ack_good_next     = ack_good_reg;
        end_received_next = end_received_reg;
        accepted          = 1'b0;
        kind              = fcp_pkg::KIND_NONE;

        if (info.frame_ok) begin
            case (info.pkg_type)
                fcp_pkg::CH_ID: begin
                    kind = fcp_pkg::KIND_ID;
                    if (!info.hash_seen) begin
                        id_valid_next = 1'b0;
                    end else begin
                        // id is updated even if the key length is wrong
                        stored_id_next = info.sign_negative ? (32'd0 - info.id_acc)
                                                            : info.id_acc;
                        if (!info.key_ok) begin
                            id_valid_next = 1'b0;
                        end else begin
                            stored_key_next  = info.key_shift;
                            id_valid_next    = 1'b1;
                            id_received_next = 1'b1;
                            accepted         = 1'b1;
                        end
                    end
                end
                fcp_pkg::CH_ACK: begin
                    kind = fcp_pkg::KIND_ACK;
                    if (info.ack_marker == fcp_pkg::CH_HASH &&
                        info.ack_digit == fcp_pkg::CH_ONE) begin
                        ack_received_next = 1'b1;
                        ack_good_next     = 1'b1;
                        accepted          = 1'b1;
                    end else if (info.ack_marker == fcp_pkg::CH_HASH &&
                                 info.ack_digit == fcp_pkg::CH_ZERO) begin
                        ack_received_next = 1'b1;
                        ack_good_next     = 1'b0;
                        accepted          = 1'b1;
                    end else begin
                        ack_received_next = 1'b0;
                        ack_good_next     = 1'b0;
                    end
                end
                fcp_pkg::CH_END: begin
                    kind              = fcp_pkg::KIND_END;
                    end_received_next = 1'b1;
                    accepted          = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_id_reg    <= 32'd0;
            stored_key_reg   <= 64'd0;
            id_valid_reg     <= 1'b0;
            id_received_reg  <= 1'b0;
            ack_received_reg <= 1'b0;
            ack_good_reg     <= 1'b0;
            end_received_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (close_pkg) begin
                stored_id_reg    <= stored_id_next;
                stored_key_reg   <= stored_key_next;
                id_valid_reg     <= id_valid_next;
                id_received_reg  <= id_received_next;
                ack_received_reg <= ack_received_next;
                ack_good_reg     <= ack_good_next;
                end_received_reg <= end_received_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (close_pkg) begin
            m_data_reg.accepted     <= accepted;
            m_data_reg.kind         <= kind;
            m_data_reg.id_value     <= stored_id_next;
            m_data_reg.key_bytes    <= stored_key_next;
            m_data_reg.id_valid     <= id_valid_next;
            m_data_reg.id_received  <= id_received_next;
            m_data_reg.ack_received <= ack_received_next;
            m_data_reg.ack_good     <= ack_good_next;
            m_data_reg.end_received <= end_received_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/fcp_checker.sv */
// Port-level checker for the framed command parser, bound to the top level.
`timescale 1ns / 1ps

module fcp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fcp_pkg::fcp_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input fcp_pkg::fcp_rsp_t m_data
);

    // No result pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A new result only follows an accepted final byte
    a_new_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid && !m_ready) |->
            $past(s_valid && s_ready && s_data.last_byte))
        else $error("result without a final byte");

    // Accepted id package leaves id flags set
    a_id_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted && m_data.kind == fcp_pkg::KIND_ID |->
            m_data.id_valid && m_data.id_received)
        else $error("accepted id without id flags");

    // Accepted ack sets the ack flag; accepted never comes with unknown kind
    a_ack_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |->
            m_data.kind != fcp_pkg::KIND_NONE &&
            (m_data.kind != fcp_pkg::KIND_ACK || m_data.ack_received))
        else $error("accepted result with bad kind or ack flag");

endmodule

bind framed_command_parser fcp_checker u_fcp_checker (.*);

/* tb/sv/framed_command_parser_tb.sv */
// Self-checking testbench for the framed command parser: random and directed byte streams.
`timescale 1ns / 1ps

module framed_command_parser_tb;

    localparam int KEY_LEN      = 8;
    localparam int HALF_PERIOD  = 6;
    localparam int BYTE_TARGET  = 550;
    localparam int DRAIN_CYCLES = 20;   // result lands in the cycle after the closing byte
    localparam int MAX_GAP      = 8;

    typedef logic [7:0] octet_q_t[$];

    // Tracks the parser's frame state and stored values, and holds the
    // results owed by the block, oldest first.
    class parse_scoreboard;
        logic [2:0]  pos;
        logic        open_seen;
        logic [7:0]  ptype;
        logic [7:0]  marker;
        logic [7:0]  digit;
        logic        hash;
        logic        stopped;
        logic        neg;
        logic [31:0] acc;
        logic [63:0] kshift;
        logic [3:0]  kcount;
        logic [31:0] id_store;
        logic [63:0] key_store;
        logic        f_idv, f_idr, f_ackr, f_ackg, f_end;
        fcp_pkg::fcp_rsp_t owed_results[$];
        int          errors;

        function new();
            errors    = 0;
            id_store  = '0;
            key_store = '0;
            {f_idv, f_idr, f_ackr, f_ackg, f_end} = '0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos       = '0;
            open_seen = 1'b0;
            ptype     = '0;
            marker    = '0;
            digit     = '0;
            hash      = 1'b0;
            stopped   = 1'b0;
            neg       = 1'b0;
            acc       = '0;
            kshift    = '0;
            kcount    = '0;
        endfunction

        function int waiting();
            return owed_results.size();
        endfunction

        // Advance the frame state by one accepted request byte.
        function void note_request(fcp_pkg::fcp_req_t req);
            logic [7:0]        b;
            fcp_pkg::fcp_rsp_t rsp;
            b = req.data_byte;
            case (pos)
                3'd0: open_seen = (b == fcp_pkg::CH_OPEN);
                3'd1: ptype = b;
                3'd2: marker = b;
                3'd3: digit = b;
                default: ;
            endcase

            if (!req.last_byte) begin
                if (pos >= 3'd3) begin
                    if (!hash) begin
                        if (b == fcp_pkg::CH_HASH) begin
                            hash = 1'b1;
                        end else if (!stopped) begin
                            if (pos == 3'd3 &&
                                (b == fcp_pkg::CH_MINUS || b == fcp_pkg::CH_PLUS)) begin
                                neg = (b == fcp_pkg::CH_MINUS);
                            end else if (b >= fcp_pkg::CH_ZERO && b <= fcp_pkg::CH_NINE) begin
                                acc = acc * 32'd10 + {24'd0, b - fcp_pkg::CH_ZERO};
                            end else begin
                                stopped = 1'b1;
                            end
                        end
                    end else begin
                        if (kcount < KEY_LEN)
                            kshift = kshift | ({56'd0, b} << (8 * kcount));
                        if (kcount <= KEY_LEN)
                            kcount++;
                    end
                end
                if (pos < 3'd4)
                    pos++;
                return;
            end

            rsp = '0;
            rsp.kind = fcp_pkg::KIND_NONE;
            if (open_seen && b == fcp_pkg::CH_CLOSE) begin
                case (ptype)
                    fcp_pkg::CH_ID: begin
                        rsp.kind = fcp_pkg::KIND_ID;
                        if (!hash) begin
                            f_idv = 1'b0;
                        end else begin
                            id_store = neg ? (32'd0 - acc) : acc;
                            if (kcount != KEY_LEN) begin
                                f_idv = 1'b0;
                            end else begin
                                key_store    = kshift;
                                f_idv        = 1'b1;
                                f_idr        = 1'b1;
                                rsp.accepted = 1'b1;
                            end
                        end
                    end
                    fcp_pkg::CH_ACK: begin
                        rsp.kind = fcp_pkg::KIND_ACK;
                        if (marker == fcp_pkg::CH_HASH &&
                            (digit == fcp_pkg::CH_ONE || digit == fcp_pkg::CH_ZERO)) begin
                            f_ackr       = 1'b1;
                            f_ackg       = (digit == fcp_pkg::CH_ONE);
                            rsp.accepted = 1'b1;
                        end else begin
                            f_ackr = 1'b0;
                            f_ackg = 1'b0;
                        end
                    end
                    fcp_pkg::CH_END: begin
                        rsp.kind     = fcp_pkg::KIND_END;
                        f_end        = 1'b1;
                        rsp.accepted = 1'b1;
                    end
                    default: ;
                endcase
            end

            rsp.id_value     = id_store;
            rsp.key_bytes    = key_store;
            rsp.id_valid     = f_idv;
            rsp.id_received  = f_idr;
            rsp.ack_received = f_ackr;
            rsp.ack_good     = f_ackg;
            rsp.end_received = f_end;
            owed_results.push_back(rsp);
            clear_frame();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(fcp_pkg::fcp_rsp_t got);
            fcp_pkg::fcp_rsp_t want;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("kind", want.kind, got.kind);
            compare_field("id_value", want.id_value, got.id_value);
            compare_field("key_bytes", want.key_bytes, got.key_bytes);
            compare_field("id_valid", want.id_valid, got.id_valid);
            compare_field("id_received", want.id_received, got.id_received);
            compare_field("ack_received", want.ack_received, got.ack_received);
            compare_field("ack_good", want.ack_good, got.ack_good);
            compare_field("end_received", want.end_received, got.end_received);
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    fcp_pkg::fcp_req_t s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    fcp_pkg::fcp_rsp_t m_data;

    parse_scoreboard board;
    int  bytes_sent = 0;
    // Steady modes give runs with no idling on either side.
    bit  src_steady = 1'b0;
    bit  snk_steady = 1'b0;

    framed_command_parser #(
        .KEY_LEN (KEY_LEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // One request per call. Entered right after a rising edge; valid is only
    // dropped when a gap is drawn, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if ($urandom_range(0, 15) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: lst};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_request('{data_byte: b, last_byte: lst});
        bytes_sent++;
    endtask

    task automatic send_frame(input octet_q_t f);
        for (int i = 0; i < f.size(); i++)
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic send_text(input string s);
        octet_q_t f;
        for (int i = 0; i < s.len(); i++)
            f.push_back(s[i]);
        send_frame(f);
    endtask

    // Mostly well-formed packages with random content; the rest is short,
    // corrupted or plain noise.
    task automatic random_frame();
        octet_q_t   f;
        int         sel;
        int         n;
        int         r;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        f.push_back(fcp_pkg::CH_OPEN);
        if (sel < 45) begin
            f.push_back(fcp_pkg::CH_ID);
            f.push_back(8'($urandom_range(0, 255)));      // byte 2 is skipped
            r = $urandom_range(0, 4);
            if (r == 0)
                f.push_back(fcp_pkg::CH_MINUS);
            else if (r == 1)
                f.push_back(fcp_pkg::CH_PLUS);
            // long digit strings push the id past 32 bits
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 10);
            repeat (n) f.push_back(8'(fcp_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    b = 8'($urandom_range(0, 255));
                    f.push_back(b == fcp_pkg::CH_HASH ? fcp_pkg::CH_PLUS : b);
                end
            end
            if ($urandom_range(0, 9) != 0)
                f.push_back(fcp_pkg::CH_HASH);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_LEN + 2) : KEY_LEN;
            repeat (n) f.push_back(8'($urandom_range(0, 255)));
            f.push_back(fcp_pkg::CH_CLOSE);
        end else if (sel < 65) begin
            f.push_back(fcp_pkg::CH_ACK);
            f.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : fcp_pkg::CH_HASH);
            r = $urandom_range(0, 9);
            f.push_back(r < 4 ? fcp_pkg::CH_ONE : r < 8 ? fcp_pkg::CH_ZERO
                                                        : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
                f.push_back(8'($urandom_range(0, 255)));
            f.push_back(fcp_pkg::CH_CLOSE);
        end else if (sel < 75) begin
            f.push_back(fcp_pkg::CH_END);
            repeat ($urandom_range(0, 2)) f.push_back(8'($urandom_range(0, 255)));
            f.push_back(fcp_pkg::CH_CLOSE);
        end else if (sel < 87) begin
            // short package: fields past the end read as zero
            r = $urandom_range(0, 3);
            if (r != 3)
                f.push_back(r == 0 ? fcp_pkg::CH_ID : r == 1 ? fcp_pkg::CH_ACK
                                                             : fcp_pkg::CH_END);
            repeat ($urandom_range(0, 1)) f.push_back(8'($urandom_range(0, 255)));
            f.push_back(fcp_pkg::CH_CLOSE);
        end else begin
            f.delete();
            repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(0, 255)));
        end
        // occasionally break the framing of an otherwise good package
        if (sel < 87 && $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0)
                f[0] = 8'($urandom_range(0, 255));
            else
                f[f.size() - 1] = 8'($urandom_range(0, 255));
        end
        send_frame(f);
    endtask

    // Result side: random stall before each result, with steady stretches.
    task automatic sink_loop();
        int gap;
        forever begin
            if ($urandom_range(0, 15) == 0)
                snk_steady = !snk_steady;
            gap = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            board.check_result(m_data);
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            sink_loop();
        join_none
        @(posedge aclk);

        // Directed: each type, good and bad ack, id without hash,
        // empty body, a lone closing byte and an unknown type.
        send_text("(E)");
        send_text("(A#1)");
        send_text("(A#0)");
        send_text("(I)");
        send_text("()");
        send_text(")");
        send_text("(Q)");

        while (bytes_sent < BYTE_TARGET)
            random_frame();
        s_valid <= 1'b0;

        while (board.waiting() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
